// File: sv/clfs_pkg.sv
`default_nettype none
package clfs_pkg;
  localparam int TableDepthDef = 16;
  localparam logic [15:0] NoWait = 16'd0;

  typedef enum logic [2:0] {
    OP_START_NOW  = 3'd0,
    OP_START_AFT  = 3'd1,
    OP_START_PAR  = 3'd2,
    OP_DELETE     = 3'd3,
    OP_TICK       = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] anim_id;
    logic [15:0] ref_id;
    logic [15:0] steps;
    logic [23:0] color_start;
    logic [26:0] color_step;
    logic [63:0] rect_start;
    logic [63:0] rect_step;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        done_flag;
    logic        active_flag;
    logic [23:0] color_out;
    logic [63:0] rect_out;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] waits_for;
    logic        running;
    logic        finished;
    logic [15:0] ticks_left;
    logic [47:0] colour;
    logic [26:0] colour_delta;
    logic [63:0] box;
    logic [63:0] box_delta;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_TICK_RD,
    S_TICK_CHK,
    S_WAKE_RD,
    S_WAKE_CHK,
    S_DONE
  } state_t;

  function automatic entry_t step_entry(entry_t e);
    entry_t r;
    logic [15:0] d;
    r = e;
    for (int k = 0; k < 3; k++) begin
      d = {{7{e.colour_delta[9*k+8]}}, e.colour_delta[9*k +: 9]};
      r.colour[16*k +: 16] = e.colour[16*k +: 16] + d;
    end
    for (int k = 0; k < 4; k++) begin
      r.box[16*k +: 16] = e.box[16*k +: 16] + e.box_delta[16*k +: 16];
    end
    r.ticks_left = e.ticks_left - 16'd1;
    if (r.ticks_left == 16'd0) begin
      r.finished = 1'b1;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// File: sv/clfs_mem.sv
`default_nettype none
module clfs_mem #(
  parameter int AW = 4,
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire clfs_pkg::entry_t wdata,
  input  wire logic [AW-1:0] raddr,
  output clfs_pkg::entry_t   rdata
);
  import clfs_pkg::*;
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/chained_linear_fade_scheduler.sv
// channel  | ports                    | transfer
// ---------+--------------------------+------------------------------
// input    | start, busy, in_item     | start && !busy
// result   | out_valid, out_item      | out_valid, one cycle, no stall
// Strobe comes in the same cycle that busy drops; start_now/start_after, a full
// table and unused opcodes go from idle straight to done. Id lookup reads and
// checks each entry in turn up to the match; delete shifts each later entry down.
// Tick steps each entry, plus a wake-up sweep per finishing entry; all set
// by the single read port. The receiver cannot stall. Reset empties the table.
`default_nettype none
module chained_linear_fade_scheduler #(
  parameter int TABLE_DEPTH = clfs_pkg::TableDepthDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire clfs_pkg::in_item_t in_item,
  output logic                   out_valid,
  output clfs_pkg::out_item_t    out_item
);
  import clfs_pkg::*;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // scan / tick index
  logic [CW-1:0] j_r, j_nxt;       // wake sweep index
  logic [15:0] wake_id_r, wake_id_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata, stepped;

  clfs_mem #(.AW(AW), .DEPTH(TABLE_DEPTH)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign stepped = step_entry(rdata);
  assign busy = (state_r != S_IDLE);

  function automatic entry_t new_entry(in_item_t q, logic [15:0] w, logic run);
    entry_t e;
    e.ident = q.anim_id;
    e.waits_for = w;
    e.running = run;
    e.finished = 1'b0;
    e.ticks_left = q.steps;
    for (int k = 0; k < 3; k++) begin
      e.colour[16*k +: 16] = {8'd0, q.color_start[8*k +: 8]};
    end
    e.colour_delta = q.color_step;
    e.box = q.rect_start;
    e.box_delta = q.rect_step;
    return e;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      out_valid <= out_valid_nxt;
    end
    if (start && !busy) begin
      req_r <= in_item;
    end
    idx_r <= idx_nxt;
    j_r <= j_nxt;
    wake_id_r <= wake_id_nxt;
    res_r <= res_nxt;
  end

  assign out_item = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op_t'(in_item.opcode))
            OP_START_NOW, OP_START_AFT: state_nxt = S_DONE;
            OP_START_PAR: state_nxt = (total_r >= CW'(TABLE_DEPTH)) ? S_DONE : S_FIND_RD;
            OP_DELETE, OP_QUERY: state_nxt = S_FIND_RD;
            OP_TICK: state_nxt = S_TICK_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FIND_RD: state_nxt = (idx_r >= total_r) ? S_DONE : S_FIND_CHK;
      S_FIND_CHK: begin
        if (rdata.ident == req_r.ref_id) begin
          state_nxt = (op_t'(req_r.opcode) == OP_DELETE) ? S_DEL_RD : S_DONE;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_DEL_RD: state_nxt = (idx_r + CW'(1) >= total_r) ? S_DONE : S_DEL_WR;
      S_DEL_WR: state_nxt = S_DEL_RD;
      S_TICK_RD: state_nxt = (idx_r >= total_r) ? S_DONE : S_TICK_CHK;
      S_TICK_CHK: begin
        if (rdata.running && !rdata.finished && stepped.finished &&
            rdata.ident != NoWait) begin
          state_nxt = S_WAKE_RD;
        end else begin
          state_nxt = S_TICK_RD;
        end
      end
      S_WAKE_RD: state_nxt = (j_r >= total_r) ? S_TICK_RD : S_WAKE_CHK;
      S_WAKE_CHK: state_nxt = S_WAKE_RD;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    raddr = idx_r[AW-1:0];
    total_nxt = total_r;
    idx_nxt = idx_r;
    j_nxt = j_r;
    wake_id_nxt = wake_id_r;
    res_nxt = res_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        res_nxt = '0;
        if (start) begin
          case (op_t'(in_item.opcode))
            OP_START_NOW, OP_START_AFT: begin
              if (total_r >= CW'(TABLE_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                we = 1'b1;
                waddr = total_r[AW-1:0];
                wdata = (op_t'(in_item.opcode) == OP_START_NOW) ?
                        new_entry(in_item, NoWait, 1'b1) :
                        new_entry(in_item, in_item.ref_id, 1'b0);
                total_nxt = total_r + CW'(1);
              end
            end
            OP_START_PAR: begin
              if (total_r >= CW'(TABLE_DEPTH)) res_nxt.status = ST_FULL;
            end
            default: ;
          endcase
        end
      end
      S_FIND_RD: begin
        if (idx_r >= total_r) begin
          res_nxt.status = ST_NOTFOUND;
          if (op_t'(req_r.opcode) == OP_QUERY) res_nxt.done_flag = 1'b1;
        end
      end
      S_FIND_CHK: begin
        if (rdata.ident == req_r.ref_id) begin
          case (op_t'(req_r.opcode))
            OP_START_PAR: begin
              we = 1'b1;
              waddr = total_r[AW-1:0];
              wdata = new_entry(req_r, rdata.waits_for, 1'b0);
              total_nxt = total_r + CW'(1);
            end
            OP_QUERY: begin
              res_nxt.done_flag = rdata.finished;
              res_nxt.active_flag = rdata.running;
              for (int k = 0; k < 3; k++) begin
                res_nxt.color_out[8*k +: 8] = rdata.colour[16*k +: 8];
              end
              res_nxt.rect_out = rdata.box;
            end
            default: ;
          endcase
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_DEL_RD: begin
        raddr = AW'(idx_r + CW'(1));
        if (idx_r + CW'(1) >= total_r) total_nxt = total_r - CW'(1);
      end
      S_DEL_WR: begin
        we = 1'b1;
        idx_nxt = idx_r + CW'(1);
      end
      S_TICK_CHK: begin
        if (rdata.running && !rdata.finished) begin
          we = 1'b1;
          wdata = stepped;
        end
        wake_id_nxt = rdata.ident;
        j_nxt = '0;
        idx_nxt = idx_r + CW'(1);
      end
      S_WAKE_RD: raddr = j_r[AW-1:0];
      S_WAKE_CHK: begin
        if (rdata.waits_for == wake_id_r) begin
          we = 1'b1;
          waddr = j_r[AW-1:0];
          wdata.running = 1'b1;
        end
        j_nxt = j_r + CW'(1);
      end
      S_DONE: out_valid_nxt = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: tb/sv/tb_chained_linear_fade_scheduler.sv
`default_nettype none
module tb_chained_linear_fade_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import clfs_pkg::*;

  localparam int Depth = TableDepthDef;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  chained_linear_fade_scheduler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler image kept by the testbench
  logic [15:0] tb_ident [Depth];
  logic [15:0] tb_waits [Depth];
  logic        tb_run [Depth];
  logic        tb_fin [Depth];
  logic [15:0] tb_ticks [Depth];
  logic [47:0] tb_col [Depth];
  logic [26:0] tb_cdel [Depth];
  logic [63:0] tb_box [Depth];
  logic [63:0] tb_bdel [Depth];
  int          tb_count = 0;

  in_item_t  pending_cmds [$];
  out_item_t expected_replies [$];
  int  mismatches = 0;
  bit  calm = 1'b0;

  function automatic int lookup_id(logic [15:0] id);
    for (int i = 0; i < tb_count; i++) begin
      if (tb_ident[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void append_entry(in_item_t c, logic [15:0] w, logic r);
    tb_ident[tb_count] = c.anim_id;
    tb_waits[tb_count] = w;
    tb_run[tb_count] = r;
    tb_fin[tb_count] = 1'b0;
    tb_ticks[tb_count] = c.steps;
    tb_col[tb_count] = {8'h0, c.color_start[23:16], 8'h0, c.color_start[15:8],
                        8'h0, c.color_start[7:0]};
    tb_cdel[tb_count] = c.color_step;
    tb_box[tb_count] = c.rect_start;
    tb_bdel[tb_count] = c.rect_step;
    tb_count++;
  endfunction

  function automatic void advance_frame();
    logic [15:0] d;
    for (int i = 0; i < tb_count; i++) begin
      if (!tb_run[i] || tb_fin[i]) continue;
      for (int k = 0; k < 3; k++) begin
        d = {{7{tb_cdel[i][9*k+8]}}, tb_cdel[i][9*k +: 9]};
        tb_col[i][16*k +: 16] = tb_col[i][16*k +: 16] + d;
      end
      for (int k = 0; k < 4; k++)
        tb_box[i][16*k +: 16] = tb_box[i][16*k +: 16] + tb_bdel[i][16*k +: 16];
      tb_ticks[i] = tb_ticks[i] - 16'd1;
      if (tb_ticks[i] != 16'd0) continue;
      tb_fin[i] = 1'b1;
      if (tb_ident[i] == NoWait) continue;
      for (int j = 0; j < tb_count; j++)
        if (tb_waits[j] == tb_ident[i]) tb_run[j] = 1'b1;
    end
  endfunction

  function automatic out_item_t schedule_reply(in_item_t c);
    out_item_t r;
    int idx;
    r = '0;
    idx = lookup_id(c.ref_id);
    case (c.opcode)
      OP_START_NOW, OP_START_AFT, OP_START_PAR: begin
        if (tb_count >= Depth) r.status = ST_FULL;
        else if (c.opcode == OP_START_NOW) append_entry(c, NoWait, 1'b1);
        else if (c.opcode == OP_START_AFT) append_entry(c, c.ref_id, 1'b0);
        else if (idx < 0) r.status = ST_NOTFOUND;
        else append_entry(c, tb_waits[idx], 1'b0);
      end
      OP_DELETE: begin
        if (idx < 0) r.status = ST_NOTFOUND;
        else begin
          for (int i = idx; i + 1 < tb_count; i++) begin
            tb_ident[i] = tb_ident[i+1]; tb_waits[i] = tb_waits[i+1];
            tb_run[i] = tb_run[i+1]; tb_fin[i] = tb_fin[i+1];
            tb_ticks[i] = tb_ticks[i+1]; tb_col[i] = tb_col[i+1];
            tb_cdel[i] = tb_cdel[i+1]; tb_box[i] = tb_box[i+1];
            tb_bdel[i] = tb_bdel[i+1];
          end
          tb_count--;
        end
      end
      OP_TICK: advance_frame();
      OP_QUERY: begin
        if (idx < 0) begin
          r.status = ST_NOTFOUND;
          r.done_flag = 1'b1;
        end else begin
          r.done_flag = tb_fin[idx];
          r.active_flag = tb_run[idx];
          r.color_out = {tb_col[idx][39:32], tb_col[idx][23:16], tb_col[idx][7:0]};
          r.rect_out = tb_box[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) expected_replies.push_back(schedule_reply(in_item));
      if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
        in_item <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        e = expected_replies.pop_front();
        if (out_item.status !== e.status || out_item.done_flag !== e.done_flag ||
            out_item.active_flag !== e.active_flag ||
            out_item.color_out !== e.color_out || out_item.rect_out !== e.rect_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d dn=%b ac=%b col=%h rect=%h, got st=%0d dn=%b ac=%b col=%h rect=%h",
              e.status, e.done_flag, e.active_flag, e.color_out, e.rect_out,
              out_item.status, out_item.done_flag, out_item.active_flag,
              out_item.color_out, out_item.rect_out);
        end
      end
    end
  end

  // small id pool so refs usually hit
  function automatic logic [15:0] pick_id();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'd1;
      2: return 16'd0;
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic in_item_t make_cmd(op_t op, logic [15:0] aid, logic [15:0] rid,
                                       logic [15:0] st);
    in_item_t c;
    c.opcode = op;
    c.anim_id = aid;
    c.ref_id = rid;
    c.steps = st;
    c.color_start = 24'($urandom);
    c.color_step = 27'($urandom);
    c.rect_start = {$urandom, $urandom};
    c.rect_step = {$urandom, $urandom};
    return c;
  endfunction

  initial begin
    in_item_t c;
    int r;
    // directed
    pending_cmds.push_back(make_cmd(OP_QUERY, 16'd5, 16'd5, 16'd1));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'd5, 16'hFFFF, 16'd1));
    pending_cmds.push_back(make_cmd(OP_START_PAR, 16'd6, 16'd7, 16'd1));
    pending_cmds.push_back(make_cmd(OP_START_NOW, 16'd1, 16'd0, 16'd2));
    pending_cmds.push_back(make_cmd(OP_START_AFT, 16'd2, 16'd1, 16'd1));
    pending_cmds.push_back(make_cmd(OP_START_PAR, 16'd3, 16'd2, 16'd3));
    pending_cmds.push_back(make_cmd(OP_START_AFT, 16'd4, 16'd999, 16'd0));
    pending_cmds.push_back(make_cmd(OP_START_NOW, 16'd0, 16'd0, 16'd1));
    pending_cmds.push_back(make_cmd(OP_START_AFT, 16'hFFFF, 16'd0, 16'hFFFF));
    c = make_cmd(OP_START_NOW, 16'd1, 16'd0, 16'd0);
    c.color_start = 24'hFFFFFF; c.color_step = 27'h7FFFFFF;
    c.rect_start = '1; c.rect_step = '1;
    pending_cmds.push_back(c);
    for (int i = 0; i < 3; i++)
      pending_cmds.push_back(make_cmd(OP_TICK, 16'd0, 16'd0, 16'd0));
    for (int i = 0; i < 4; i++)
      pending_cmds.push_back(make_cmd(OP_QUERY, 16'd0, 16'(i+1), 16'd0));
    pending_cmds.push_back(make_cmd(op_t'(3'd6), 16'd0, 16'd0, 16'd0));
    pending_cmds.push_back(make_cmd(op_t'(3'd7), 16'hFFFF, 16'hFFFF, 16'hFFFF));
    for (int i = 0; i < 8; i++)
      pending_cmds.push_back(make_cmd(OP_START_NOW, 16'd9, 16'd0, 16'd3));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'd0, 16'd1, 16'd0));
    pending_cmds.push_back(make_cmd(OP_START_AFT, 16'd8, 16'd9, 16'd2));
    // random: mostly chains with ticks and queries
    for (int n = 0; n < 750; n++) begin
      r = $urandom_range(99);
      if (r < 18) c = make_cmd(OP_START_NOW, pick_id(), pick_id(),
                               $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4)));
      else if (r < 30) c = make_cmd(OP_START_AFT, pick_id(), pick_id(), 16'($urandom_range(4)));
      else if (r < 38) c = make_cmd(OP_START_PAR, pick_id(), pick_id(), 16'($urandom_range(4)));
      else if (r < 50) c = make_cmd(OP_DELETE, pick_id(), pick_id(), 16'd0);
      else if (r < 72) c = make_cmd(OP_TICK, pick_id(), pick_id(), 16'd0);
      else if (r < 96) c = make_cmd(OP_QUERY, pick_id(), pick_id(), 16'd0);
      else c = make_cmd(op_t'(3'($urandom_range(7))), 16'($urandom), 16'($urandom),
                        16'($urandom));
      pending_cmds.push_back(c);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() < 600);
    calm = 1'b1;
    wait (pending_cmds.size() < 450);
    calm = 1'b0;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

// File: chained_linear_fade_scheduler.f
sv/clfs_pkg.sv
sv/clfs_mem.sv
sv/chained_linear_fade_scheduler.sv
tb/sv/tb_chained_linear_fade_scheduler.sv
